// ===== hdl/pidaw_pkg.sv =====
// ----------------------------------------------------------------------------
// pidaw_pkg: shared types and constants of the PID controller
// Field widths, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none
package pidaw_pkg;
	localparam int unsigned DataW  = 16;
	localparam int unsigned AccW   = 40;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_PROP_GAIN  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_OUT_LOW    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_OUT_HIGH   = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_INTEG_LOW  = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_INTEG_HIGH = 3'd6;

	localparam logic [15:0] PROP_GAIN_RST = 16'd256;

	localparam logic CMD_RUN   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] integ_gain;
		logic [15:0] deriv_gain;
		logic signed [15:0] out_low;
		logic signed [15:0] out_high;
		logic signed [15:0] integ_low;
		logic signed [15:0] integ_high;
	} cfg_t;

	// Control from the sequencer to the serial units.
	typedef struct packed {
		logic load;
		logic step;
	} unit_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/pidaw_if.sv =====
// ----------------------------------------------------------------------------
// pidaw_if: valid/ready channels of the PID controller
// Input, output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none
interface pidaw_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic signed [15:0] setpoint;
	logic signed [15:0] sample;
	logic [15:0] step_time;
	modport source (output valid, cmd, setpoint, sample, step_time, input ready);
	modport sink (input valid, cmd, setpoint, sample, step_time, output ready);
endinterface

interface pidaw_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] drive;
	logic status;
	modport source (output valid, drive, status, input ready);
	modport sink (input valid, drive, status, output ready);
endinterface

interface pidaw_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pidaw_sermul.sv =====
// ----------------------------------------------------------------------------
// pidaw_sermul: shift-add multiplier, one multiplier bit per cycle while ctl.step is high
// Unsigned multiplier times signed multiplicand, exact product.
// ----------------------------------------------------------------------------
`default_nettype none
module pidaw_sermul #(
	parameter int unsigned MW = 16,
	parameter int unsigned AW = 34
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pidaw_pkg::unit_ctl_t ctl,
	input  wire logic [MW-1:0] mplier,
	input  wire logic signed [AW-1:0] mcand,
	output logic signed [AW+MW-1:0] prod
);
	logic [MW-1:0] mp_q;
	logic signed [AW+MW-1:0] mc_q;
	logic signed [AW+MW-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.load) begin
			acc_q <= '0;
		end else if (ctl.step) begin
			if (mp_q[0]) acc_q <= acc_q + mc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mp_q <= mplier;
			mc_q <= (AW+MW)'(mcand);
		end else if (ctl.step) begin
			mp_q <= mp_q >> 1;
			mc_q <= mc_q <<< 1;
		end
	end

	assign prod = acc_q;
endmodule
`default_nettype wire

// ===== hdl/pidaw_serdiv.sv =====
// ----------------------------------------------------------------------------
// pidaw_serdiv: restoring divider, one quotient bit per cycle while ctl.step is high
// Unsigned magnitude divide; sign is applied by the caller.
// ----------------------------------------------------------------------------
`default_nettype none
module pidaw_serdiv #(
	parameter int unsigned NW = 57,
	parameter int unsigned DW = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pidaw_pkg::unit_ctl_t ctl,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic [NW-1:0] quot
);
	logic [NW-1:0] q_q;
	logic [DW:0] rem_q;
	logic [DW-1:0] den_q;
	logic [DW:0] trial;

	assign trial = {rem_q[DW-1:0], q_q[NW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ctl.load) begin
			rem_q <= '0;
		end else if (ctl.step) begin
			if (!trial[DW]) rem_q <= trial;
			else rem_q <= {rem_q[DW-1:0], q_q[NW-1]};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			q_q   <= num;
			den_q <= den;
		end else if (ctl.step) begin
			q_q <= {q_q[NW-2:0], ~trial[DW]};
		end
	end

	assign quot = q_q;
endmodule
`default_nettype wire

// ===== hdl/pid_controller_antiwindup.sv =====
// ----------------------------------------------------------------------------
// pid_controller_antiwindup: fixed-point PID step with anti-windup
// Bit-serial multipliers and divider under a small sequencer.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload
// in      | in  | cmd, setpoint, sample, step_time
// result  | out | drive, status
// cfg     | in  | index, data (register write)
//
// A run transaction holds the sequencer through multiply (two shift-add passes over
// the 16 multiplier bits), divide (load plus 57 quotient bits), sum and output;
// the result is registered in the output state, and the next input is taken only
// once the sequencer is idle again and the result slot is empty. The bit-serial
// divider of the derivative term takes most of the run.
// Clear and error transactions bypass the sequencer; their result is set at accept.
// Reset clears the integral, history, state and registers to their defaults.
// A held result stalls only the next input; cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none
module pid_controller_antiwindup (
	input  wire logic clk,
	input  wire logic arst_n,
	pidaw_in_if.sink   in_ch,
	pidaw_out_if.source res_ch,
	pidaw_cfg_if.sink  cfg
);
	localparam int unsigned MulW = 26;   // multiplicand width of the 16b gain products
	localparam int unsigned DivN = 57;   // |deriv_gain*dm|<<24 magnitude width

	pidaw_pkg::cfg_t cfg_q;
	pidaw_pkg::state_t st_q, st_d;
	logic [6:0] cnt_q;
	logic signed [39:0] integ_q;
	logic signed [15:0] last_q;
	logic have_q;

	logic signed [16:0] err_q;
	logic signed [16:0] dm_q;
	logic [15:0] dt_q;
	logic signed [15:0] meas_q;
	logic out_v_q;
	logic signed [15:0] drive_q;
	logic status_q;

	// Accept transaction only when the sequencer is idle and the result slot empty.
	assign in_ch.ready = (st_q == pidaw_pkg::ST_IDLE) && !out_v_q;
	assign cfg.ready   = 1'b1;
	wire in_acc = in_ch.valid && in_ch.ready;
	wire bad_cfg = (cfg_q.out_low >= cfg_q.out_high) ||
		(cfg_q.integ_low > cfg_q.integ_high);

	// Multipliers: integ_gain*e, deriv_gain*dm. P is a small 16x17 product.
	pidaw_pkg::unit_ctl_t mctl, dctl;
	logic signed [41:0] ie_prod;
	logic signed [41:0] dg_prod;

	// The integral term forms integ_gain*e first; a second pass in u_mul_t multiplies by dt.
	pidaw_sermul #(.MW(16), .AW(MulW)) u_mul_i (
		.clk, .arst_n, .ctl(mctl), .mplier(cfg_q.integ_gain),
		.mcand(MulW'(err_q)), .prod(ie_prod));
	pidaw_sermul #(.MW(16), .AW(MulW)) u_mul_d (
		.clk, .arst_n, .ctl(mctl), .mplier(cfg_q.deriv_gain),
		.mcand(MulW'(dm_q)), .prod(dg_prod));

	// Second pass: (integ_gain*e) * dt, with its own unit ctl, loaded after the first pass.
	logic signed [48:0] ig2_prod;
	pidaw_pkg::unit_ctl_t m2ctl;
	pidaw_sermul #(.MW(16), .AW(33)) u_mul_t (
		.clk, .arst_n, .ctl(m2ctl), .mplier(dt_q),
		.mcand(33'(ie_prod)), .prod(ig2_prod));

	logic [DivN-1:0] div_num;
	logic [DivN-1:0] div_q;
	logic signed [33:0] dgp;
	assign dgp = 34'(dg_prod);
	assign div_num = {(DivN-24)'(dgp[33] ? -dgp : dgp), 24'd0};
	pidaw_serdiv #(.NW(DivN), .DW(16)) u_div (
		.clk, .arst_n, .ctl(dctl), .num(div_num), .den(dt_q), .quot(div_q));

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= pidaw_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		mctl = '0; m2ctl = '0; dctl = '0;
		unique case (st_q)
			pidaw_pkg::ST_IDLE: begin
				if (in_acc && in_ch.cmd == pidaw_pkg::CMD_RUN &&
					in_ch.step_time != '0 && !bad_cfg) st_d = pidaw_pkg::ST_MUL;
			end
			pidaw_pkg::ST_MUL: begin
				mctl.load = (cnt_q == 7'd0);
				mctl.step = (cnt_q != 7'd0) && (cnt_q <= 7'd16);
				m2ctl.load = (cnt_q == 7'd17);
				m2ctl.step = (cnt_q > 7'd17);
				if (cnt_q == 7'd33) st_d = pidaw_pkg::ST_DIV;
			end
			pidaw_pkg::ST_DIV: begin
				dctl.load = (cnt_q == 7'd0);
				dctl.step = (cnt_q != 7'd0);
				if (cnt_q == 7'(DivN)) st_d = pidaw_pkg::ST_SUM;
			end
			pidaw_pkg::ST_SUM: st_d = pidaw_pkg::ST_OUT;
			pidaw_pkg::ST_OUT: st_d = pidaw_pkg::ST_IDLE;
			default: st_d = pidaw_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (st_d != st_q) cnt_q <= '0;
		else cnt_q <= cnt_q + 7'd1;
	end

	// Final arithmetic, split over SUM and OUT.
	logic signed [63:0] inc_s, p_s, d_s, cand_s, u_s;
	logic signed [63:0] ilo, ihi, olo, ohi, y_s;
	logic signed [63:0] p_q, cand_q, d_q;
	logic commit_q;
	always_comb begin
		inc_s  = 64'(ig2_prod) >>> 8;
		p_s    = 64'(cfg_q.prop_gain) * 64'(err_q);
		p_s    = p_s <<< 8;
		d_s    = have_q ? (dgp[33] ? 64'(div_q) : -64'(div_q)) : 64'sd0;
		ilo    = 64'(cfg_q.integ_low) <<< 16;
		ihi    = 64'(cfg_q.integ_high) <<< 16;
		olo    = 64'(cfg_q.out_low) <<< 16;
		ohi    = 64'(cfg_q.out_high) <<< 16;
		cand_s = 64'(integ_q) + inc_s;
		if (cand_s < ilo) cand_s = ilo;
		else if (cand_s > ihi) cand_s = ihi;
		u_s = p_q + cand_q + d_q;
		// The committed sum is u itself; the held one is formed alongside.
		y_s = commit_q ? u_s : (p_q + 64'(integ_q) + d_q);
		if (y_s < olo) y_s = olo;
		else if (y_s > ohi) y_s = ohi;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			err_q  <= 17'(in_ch.setpoint) - 17'(in_ch.sample);
			dm_q   <= 17'(in_ch.sample) - 17'(last_q);
			dt_q   <= in_ch.step_time;
			meas_q <= in_ch.sample;
		end
		if (st_q == pidaw_pkg::ST_SUM) begin
			p_q <= p_s; cand_q <= cand_s; d_q <= d_s;
		end
	end
	always_comb commit_q = !((u_s > ohi && err_q > 0) || (u_s < olo && err_q < 0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{pidaw_pkg::PROP_GAIN_RST, 16'd0, 16'd0, -16'sd32768, 16'sd32767,
				-16'sd32768, 16'sd32767};
			integ_q <= '0; last_q <= '0; have_q <= 1'b0;
			out_v_q <= 1'b0; drive_q <= '0; status_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					pidaw_pkg::REG_PROP_GAIN:  cfg_q.prop_gain  <= cfg.data;
					pidaw_pkg::REG_INTEG_GAIN: cfg_q.integ_gain <= cfg.data;
					pidaw_pkg::REG_DERIV_GAIN: cfg_q.deriv_gain <= cfg.data;
					pidaw_pkg::REG_OUT_LOW:    cfg_q.out_low    <= cfg.data;
					pidaw_pkg::REG_OUT_HIGH:   cfg_q.out_high   <= cfg.data;
					pidaw_pkg::REG_INTEG_LOW:  cfg_q.integ_low  <= cfg.data;
					pidaw_pkg::REG_INTEG_HIGH: cfg_q.integ_high <= cfg.data;
					default: ;
				endcase
			end
			if (res_ch.valid && res_ch.ready) out_v_q <= 1'b0;
			if (in_acc && st_d == pidaw_pkg::ST_IDLE) begin
				out_v_q <= 1'b1; drive_q <= '0;
				status_q <= (in_ch.cmd == pidaw_pkg::CMD_RUN);
				if (in_ch.cmd == pidaw_pkg::CMD_CLEAR) begin
					integ_q <= '0; last_q <= '0; have_q <= 1'b0;
				end
			end
			if (st_q == pidaw_pkg::ST_OUT) begin
				if (commit_q) integ_q <= 40'(cand_q);
				last_q <= meas_q; have_q <= 1'b1;
				drive_q <= 16'(y_s >>> 16); status_q <= 1'b0; out_v_q <= 1'b1;
			end
		end
	end

	assign res_ch.valid  = out_v_q;
	assign res_ch.drive  = drive_q;
	assign res_ch.status = status_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != pidaw_pkg::ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
	a_out_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == pidaw_pkg::ST_OUT) |=> out_v_q) else $error("result lost");
	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == pidaw_pkg::ST_OUT) |=> !status_q) else $error("bad status");
endmodule
`default_nettype wire
